// ===== hdl/sctd_pkg.sv =====
// ----------------------------------------------------------------------------
// sctd_pkg
// Shared constants, types and the month length table for the seconds to
// calendar date unit.
// ----------------------------------------------------------------------------
package sctd_pkg;

  localparam int unsigned SecsW       = 32;
  localparam int unsigned TodW        = 17;
  localparam int unsigned DaysW       = 16;
  localparam int unsigned BlockRemW   = 11;
  localparam int unsigned BlockCntW   = 6;
  localparam int unsigned MinsW       = 11;
  localparam int unsigned SixtyW      = 6;

  localparam int unsigned YearW       = 12;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned MdayW       = 5;
  localparam int unsigned HourW       = 5;
  localparam int unsigned MinuteW     = 6;
  localparam int unsigned SecondW     = 6;
  localparam int unsigned WeekdayW    = 3;

  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 48;

  localparam logic [TodW-1:0]      SecsPerDay   = 17'd86400;
  localparam logic [SixtyW-1:0]    Sixty        = 6'd60;
  localparam logic [BlockRemW-1:0] DaysPerBlock = 11'd1461;
  localparam logic [DaysW-1:0]     ShiftToBase  = 16'd731;
  localparam logic [DaysW-1:0]     FirstBadDay  = 16'd47482;
  localparam logic [YearW-1:0]     BaseYear     = 12'd1968;
  localparam logic [BlockRemW-1:0] LeapYearLen  = 11'd366;
  localparam logic [BlockRemW-1:0] YearLen      = 11'd365;
  localparam logic [MonthW-1:0]    LastMonthIdx = 4'd11;

  // values pinned once the count lies past the end of 2099
  localparam logic [YearW-1:0]     PinYear      = 12'd2099;
  localparam logic [MonthW-1:0]    PinMonth     = 4'd12;
  localparam logic [MdayW-1:0]     PinMday      = 5'd31;
  localparam logic [WeekdayW-1:0]  PinWeekday   = 3'd4;

  // 1970-01-01 was a thursday
  localparam logic [WeekdayW-1:0]  EpochWdayOfs = 3'd3;
  localparam logic [WeekdayW-1:0]  DaysPerWeek  = 3'd7;

  // status of a serial divider
  typedef struct packed {
    logic busy;
    logic step;
    logic qbit;
    logic done;
  } div_stat_t;

  // month length by zero based month index, february fixed in leap years
  function automatic logic [MdayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [MdayW-1:0] len;
    unique case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/sctd_div.sv =====
// ----------------------------------------------------------------------------
// sctd_div
// Restoring bit-serial divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sctd_div #(
  parameter int unsigned W  = sctd_pkg::SecsW,
  parameter int unsigned DW = sctd_pkg::TodW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        dividend_i,
  input  logic [DW-1:0]       divisor_i,
  output sctd_pkg::div_stat_t stat_o,
  output logic [W-1:0]        quot_o,
  output logic [DW-1:0]       rem_o
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  sh_q, sh_d;
  logic [DW-1:0] rem_q, rem_d;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, sh_q[W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_d  = {sh_q[W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.step = busy_q;
  assign stat_o.qbit = ge;
  assign stat_o.done = done_q;
  assign quot_o      = sh_q;
  assign rem_o       = rem_q;

endmodule

// ===== hdl/sctd_cal.sv =====
// ----------------------------------------------------------------------------
// sctd_cal
// Day count to year, month and day of month: four-year blocks from 1968,
// then a year walk and a month walk of one step per cycle.
// ----------------------------------------------------------------------------
module sctd_cal (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sctd_pkg::DaysW-1:0]     days_i,
  output logic                           done_o,
  output logic [sctd_pkg::YearW-1:0]     year_o,
  output logic [sctd_pkg::MonthW-1:0]    month_o,
  output logic [sctd_pkg::MdayW-1:0]     mday_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH
  } state_e;

  state_e                            state_q;
  logic                              done_q;
  logic [sctd_pkg::BlockRemW-1:0]    r_q;
  logic [1:0]                        yoff_q;
  logic                              leap_q;
  logic [sctd_pkg::MonthW-1:0]       m_q;
  logic [sctd_pkg::YearW-1:0]        year_q;
  logic [sctd_pkg::MonthW-1:0]       month_q;
  logic [sctd_pkg::MdayW-1:0]        mday_q;

  sctd_pkg::div_stat_t               bdiv_stat;
  logic [sctd_pkg::DaysW-1:0]        bdiv_quot;
  logic [sctd_pkg::BlockRemW-1:0]    bdiv_rem;
  logic [sctd_pkg::DaysW-1:0]        shifted_days;
  logic [sctd_pkg::MdayW-1:0]        len;
  logic [sctd_pkg::YearW-1:0]        year_sum;

  assign shifted_days = days_i + sctd_pkg::ShiftToBase;

  sctd_div #(
    .W  (sctd_pkg::DaysW),
    .DW (sctd_pkg::BlockRemW)
  ) u_bdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .dividend_i (shifted_days),
    .divisor_i  (sctd_pkg::DaysPerBlock),
    .stat_o     (bdiv_stat),
    .quot_o     (bdiv_quot),
    .rem_o      (bdiv_rem)
  );

  assign len = sctd_pkg::month_len(m_q, leap_q);
  assign year_sum = sctd_pkg::BaseYear
                  + {{(sctd_pkg::YearW-sctd_pkg::BlockCntW-2){1'b0}},
                     bdiv_quot[sctd_pkg::BlockCntW-1:0], 2'b00}
                  + {{(sctd_pkg::YearW-2){1'b0}}, yoff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      r_q     <= '0;
      yoff_q  <= '0;
      leap_q  <= 1'b0;
      m_q     <= '0;
      year_q  <= '0;
      month_q <= '0;
      mday_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (bdiv_stat.done) begin
            r_q     <= bdiv_rem;
            yoff_q  <= 2'd0;
            leap_q  <= 1'b1;
            state_q <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          m_q <= '0;
          if (yoff_q == 2'd0) begin
            if (r_q < sctd_pkg::LeapYearLen) begin
              state_q <= ST_MONTH;
            end else begin
              r_q    <= r_q - sctd_pkg::LeapYearLen;
              yoff_q <= 2'd1;
              leap_q <= 1'b0;
            end
          end else if (r_q >= sctd_pkg::YearLen) begin
            r_q    <= r_q - sctd_pkg::YearLen;
            yoff_q <= yoff_q + 2'd1;
          end else begin
            state_q <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if ((m_q == sctd_pkg::LastMonthIdx) ||
              (r_q < {{(sctd_pkg::BlockRemW-sctd_pkg::MdayW){1'b0}}, len})) begin
            year_q  <= year_sum;
            month_q <= m_q + 1'b1;
            mday_q  <= r_q[sctd_pkg::MdayW-1:0] + 1'b1;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            r_q <= r_q - {{(sctd_pkg::BlockRemW-sctd_pkg::MdayW){1'b0}}, len};
            m_q <= m_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign year_o  = year_q;
  assign month_o = month_q;
  assign mday_o  = mday_q;

endmodule

// ===== hdl/seconds_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_unit
// Flow: a serial divide by 86400 of each accepted input transaction, then the
// two chained time-of-day divides by 60 alongside the block divide by 1461
// with its year and month walks. One item at a time: a new input is taken
// only once the previous result is loaded, which waits while a stalled
// receiver still holds the result before it.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // epoch_seconds
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sctd_pkg::InDataW-1:0]      s_axis_tdata_i,
  // year, month, day_of_month, hour, minute, second, weekday, zero padding
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sctd_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // out_of_range
  output logic                              m_axis_tuser_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DAY,
    ST_WORK,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic                            m_valid_q;
  logic [sctd_pkg::OutDataW-1:0]   m_data_q;
  logic                            m_user_q;
  logic                            tdone_q;
  logic                            cdone_q;
  logic [sctd_pkg::WeekdayW-1:0]   wacc_q;

  logic                            accept;
  logic                            work_start;
  logic                            t2_start;

  sctd_pkg::div_stat_t             ddiv_stat, t1_stat, t2_stat;
  logic [sctd_pkg::SecsW-1:0]      ddiv_quot;
  logic [sctd_pkg::TodW-1:0]       ddiv_rem;
  logic [sctd_pkg::TodW-1:0]       t1_quot;
  logic [sctd_pkg::SixtyW-1:0]     t1_rem;
  logic [sctd_pkg::MinsW-1:0]      t2_quot;
  logic [sctd_pkg::SixtyW-1:0]     t2_rem;

  logic                            cal_done;
  logic [sctd_pkg::YearW-1:0]      cal_year;
  logic [sctd_pkg::MonthW-1:0]     cal_month;
  logic [sctd_pkg::MdayW-1:0]      cal_mday;

  logic [sctd_pkg::DaysW-1:0]      days;
  logic                            oor;
  logic [sctd_pkg::WeekdayW:0]     wacc_dbl;
  logic [sctd_pkg::WeekdayW-1:0]   wacc_next;
  logic [sctd_pkg::WeekdayW:0]     wsum;
  logic [sctd_pkg::WeekdayW-1:0]   wday;
  logic [sctd_pkg::YearW-1:0]      o_year;
  logic [sctd_pkg::MonthW-1:0]     o_month;
  logic [sctd_pkg::MdayW-1:0]      o_mday;
  logic [sctd_pkg::WeekdayW-1:0]   o_wday;
  logic [sctd_pkg::OutDataW-1:0]   o_data;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign work_start      = (state_q == ST_DAY) && ddiv_stat.done;
  assign t2_start        = t1_stat.done;

  sctd_div #(
    .W  (sctd_pkg::SecsW),
    .DW (sctd_pkg::TodW)
  ) u_ddiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (s_axis_tdata_i),
    .divisor_i  (sctd_pkg::SecsPerDay),
    .stat_o     (ddiv_stat),
    .quot_o     (ddiv_quot),
    .rem_o      (ddiv_rem)
  );

  // seconds of day / 60 -> minutes of day, second
  sctd_div #(
    .W  (sctd_pkg::TodW),
    .DW (sctd_pkg::SixtyW)
  ) u_t1div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (work_start),
    .dividend_i (ddiv_rem),
    .divisor_i  (sctd_pkg::Sixty),
    .stat_o     (t1_stat),
    .quot_o     (t1_quot),
    .rem_o      (t1_rem)
  );

  // minutes of day / 60 -> hour, minute
  sctd_div #(
    .W  (sctd_pkg::MinsW),
    .DW (sctd_pkg::SixtyW)
  ) u_t2div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (t2_start),
    .dividend_i (t1_quot[sctd_pkg::MinsW-1:0]),
    .divisor_i  (sctd_pkg::Sixty),
    .stat_o     (t2_stat),
    .quot_o     (t2_quot),
    .rem_o      (t2_rem)
  );

  assign days = ddiv_quot[sctd_pkg::DaysW-1:0];

  sctd_cal u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (work_start),
    .days_i  (days),
    .done_o  (cal_done),
    .year_o  (cal_year),
    .month_o (cal_month),
    .mday_o  (cal_mday)
  );

  // day count mod 7 built from the quotient bits as they come out
  assign wacc_dbl  = {wacc_q, ddiv_stat.qbit};
  assign wacc_next = (wacc_dbl >= {1'b0, sctd_pkg::DaysPerWeek})
                   ? sctd_pkg::WeekdayW'(wacc_dbl - {1'b0, sctd_pkg::DaysPerWeek})
                   : wacc_dbl[sctd_pkg::WeekdayW-1:0];

  assign wsum = {1'b0, wacc_q} + {1'b0, sctd_pkg::EpochWdayOfs};
  assign wday = ((wsum >= {1'b0, sctd_pkg::DaysPerWeek})
              ? sctd_pkg::WeekdayW'(wsum - {1'b0, sctd_pkg::DaysPerWeek})
              : wsum[sctd_pkg::WeekdayW-1:0]) + 1'b1;

  assign oor     = (days >= sctd_pkg::FirstBadDay);
  assign o_year  = oor ? sctd_pkg::PinYear    : cal_year;
  assign o_month = oor ? sctd_pkg::PinMonth   : cal_month;
  assign o_mday  = oor ? sctd_pkg::PinMday    : cal_mday;
  assign o_wday  = oor ? sctd_pkg::PinWeekday : wday;

  assign o_data = {7'd0, o_wday, t1_rem, t2_rem,
                   t2_quot[sctd_pkg::HourW-1:0], o_mday, o_month, o_year};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
      tdone_q   <= 1'b0;
      cdone_q   <= 1'b0;
      wacc_q    <= '0;
    end else begin
      // in ST_EMIT the output register is reloaded below instead
      if (m_valid_q && m_axis_tready_i && (state_q != ST_EMIT)) m_valid_q <= 1'b0;
      if (ddiv_stat.step) wacc_q <= wacc_next;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            wacc_q  <= '0;
            tdone_q <= 1'b0;
            cdone_q <= 1'b0;
            state_q <= ST_DAY;
          end
        end
        ST_DAY: begin
          if (ddiv_stat.done) state_q <= ST_WORK;
        end
        ST_WORK: begin
          if (t2_stat.done) tdone_q <= 1'b1;
          if (cal_done) cdone_q <= 1'b1;
          if (tdone_q && cdone_q) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // the output register may still hold the previous transaction
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= o_data;
            m_user_q  <= oor;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== bench/tb_seconds_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar_date_unit
// Streams epoch second counts into the unit and checks each calendar result
// against a predicted year, month, day, time of day, weekday and range flag.
// Directed edge dates come first, then random counts spread over the valid
// span and beyond it, with random gaps, receiver stalls, a long receiver
// hold-off and a full drain between bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date_unit;

  localparam int unsigned SecsInDay    = 86400;
  localparam int unsigned DaysInBlock  = 1461;
  localparam int unsigned DaysFrom1968 = 731;
  localparam int unsigned DaysTo2100   = 47482;
  localparam logic [31:0] LastGoodSecs = 32'd4102444799;
  localparam logic [31:0] FirstBadSecs = 32'd4102444800;

  localparam int ReadyAlways   = 0;
  localparam int ReadyRandom   = 1;
  localparam int ReadyPeriodic = 2;

  typedef struct {
    logic [31:0]                   secs;
    logic [sctd_pkg::YearW-1:0]    year;
    logic [sctd_pkg::MonthW-1:0]   month;
    logic [sctd_pkg::MdayW-1:0]    mday;
    logic [sctd_pkg::HourW-1:0]    hour;
    logic [sctd_pkg::MinuteW-1:0]  minute;
    logic [sctd_pkg::SecondW-1:0]  second;
    logic [sctd_pkg::WeekdayW-1:0] weekday;
    logic                          out_of_range;
  } calendar_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [sctd_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [sctd_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;

  calendar_t pending_dates[$];
  int        mismatch_count = 0;

  // sender burst state
  bit gaps_on = 1'b1;
  int burst_left = 0;

  // receiver state; hold_request is set by a test and taken over here
  int hold_request = 0;
  int hold_left = 0;
  int ready_mode = ReadyAlways;
  int mode_left = 0;

  int month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  always #4 clk_i = ~clk_i;

  seconds_to_calendar_date_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    int unsigned days, tod, blk_day, doy, mon, len, yr;
    bit          leap;
    calendar_t   c;
    days = secs / SecsInDay;
    tod  = secs % SecsInDay;
    c.secs   = secs;
    c.second = sctd_pkg::SecondW'(tod % 60);
    c.minute = sctd_pkg::MinuteW'((tod / 60) % 60);
    c.hour   = sctd_pkg::HourW'(tod / 3600);
    c.out_of_range = (days >= DaysTo2100);
    if (c.out_of_range) begin
      c.year = 12'd2099; c.month = 4'd12; c.mday = 5'd31; c.weekday = 3'd4;
    end else begin
      // four-year blocks from 1968, the first year of each is the leap one
      blk_day = (days + DaysFrom1968) % DaysInBlock;
      yr      = 1968 + 4 * ((days + DaysFrom1968) / DaysInBlock);
      if (blk_day < 366) begin
        leap = 1'b1;
        doy  = blk_day;
      end else begin
        leap = 1'b0;
        yr   = yr + 1 + (blk_day - 366) / 365;
        doy  = (blk_day - 366) % 365;
      end
      mon = 0;
      while (mon < 11) begin
        len = month_days[mon] + ((mon == 1 && leap) ? 1 : 0);
        if (doy < len) break;
        doy -= len;
        mon++;
      end
      c.year    = sctd_pkg::YearW'(yr);
      c.month   = sctd_pkg::MonthW'(mon + 1);
      c.mday    = sctd_pkg::MdayW'(doy + 1);
      c.weekday = sctd_pkg::WeekdayW'((days + 3) % 7 + 1);  // the epoch fell on a thursday
    end
    return c;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] secs,
                                 input int got, input int want);
    $display("mismatch %s for %0d s: got %0d, expected %0d", field, secs, got, want);
    mismatch_count++;
  endtask

  // offer one count and hold it until the transaction completes
  task automatic send_seconds(input logic [31:0] secs);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= secs;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_dates.push_back(calendar_of(secs));
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
        burst_left = $urandom_range(10, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] secs_of(input int unsigned days, input int unsigned tod);
    return days * SecsInDay + tod;
  endfunction

  function automatic logic [31:0] random_seconds();
    int unsigned tod;
    case ($urandom_range(9, 0))
      6, 7: begin
        // day boundaries or a random time of day inside the valid span
        case ($urandom_range(2, 0))
          0:       tod = 0;
          1:       tod = SecsInDay - 1;
          default: tod = $urandom_range(SecsInDay - 1, 0);
        endcase
        return secs_of($urandom_range(DaysTo2100 - 1, 0), tod);
      end
      8:       return $urandom_range(32'hFFFF_FFFF, FirstBadSecs);
      9:       return $urandom;
      default: return $urandom_range(LastGoodSecs, 0);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result", '0, int'(m_axis_tvalid_o), 0);
      end else begin
        want = pending_dates.pop_front();
        if (m_axis_tdata_o[11:0] !== want.year)
          report_mismatch("year", want.secs, int'(m_axis_tdata_o[11:0]), int'(want.year));
        if (m_axis_tdata_o[15:12] !== want.month)
          report_mismatch("month", want.secs, int'(m_axis_tdata_o[15:12]),
                          int'(want.month));
        if (m_axis_tdata_o[20:16] !== want.mday)
          report_mismatch("day", want.secs, int'(m_axis_tdata_o[20:16]), int'(want.mday));
        if (m_axis_tdata_o[25:21] !== want.hour)
          report_mismatch("hour", want.secs, int'(m_axis_tdata_o[25:21]), int'(want.hour));
        if (m_axis_tdata_o[31:26] !== want.minute)
          report_mismatch("minute", want.secs, int'(m_axis_tdata_o[31:26]),
                          int'(want.minute));
        if (m_axis_tdata_o[37:32] !== want.second)
          report_mismatch("second", want.secs, int'(m_axis_tdata_o[37:32]),
                          int'(want.second));
        if (m_axis_tdata_o[40:38] !== want.weekday)
          report_mismatch("weekday", want.secs, int'(m_axis_tdata_o[40:38]),
                          int'(want.weekday));
        if (m_axis_tdata_o[47:41] !== '0)
          report_mismatch("padding", want.secs, int'(m_axis_tdata_o[47:41]), 0);
        if (m_axis_tuser_o !== want.out_of_range)
          report_mismatch("out_of_range", want.secs, int'(m_axis_tuser_o),
                          int'(want.out_of_range));
      end
    end
  end

  // receiver: a long hold-off on request, otherwise changing stall patterns
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(ReadyPeriodic, ReadyAlways);
        mode_left  = $urandom_range(300, 30);
      end
      mode_left--;
      case (ready_mode)
        ReadyAlways: m_axis_tready_i <= 1'b1;
        ReadyRandom: m_axis_tready_i <= ($urandom_range(2, 0) != 0);
        default:     m_axis_tready_i <= ((mode_left % 11) < 6);
      endcase
    end
  end

  task automatic test_directed_dates();
    logic [31:0] edge_secs[$];
    edge_secs = '{
      32'd0,                         // the epoch itself
      32'd59, 32'd3599, 32'd86399,   // end of first minute, hour and day
      32'd86400,
      32'd31535999, 32'd31536000,    // new year 1971
      secs_of(789, 0),               // 1972-02-29
      secs_of(790, 0),               // 1972-03-01
      secs_of(1095, 86399),          // last second of leap year 1972
      secs_of(10956, 86399),         // last second of 1999
      secs_of(11016, 43210),         // 2000-02-29, leap under the century rule
      secs_of(11017, 0),
      32'h7FFF_FFFF, 32'h8000_0000,  // signed 32-bit rollover
      secs_of(46080, 1),             // 2096-02-29
      LastGoodSecs,                  // last second of 2099
      FirstBadSecs,                  // first count past 2099
      FirstBadSecs + SecsInDay - 1,
      32'h5555_5555, 32'hAAAA_AAAA,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    foreach (edge_secs[i]) send_seconds(edge_secs[i]);
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) begin
      if ($urandom_range(99, 0) == 0) gaps_on = ~gaps_on;
      send_seconds(random_seconds());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_beyond_2099(input int count);
    repeat (count) send_seconds($urandom_range(32'hFFFF_FFFF, FirstBadSecs));
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_receiver_hold_off();
    gaps_on = 1'b0;
    hold_request = 600;
    repeat (20) send_seconds(random_seconds());
    gaps_on = 1'b1;
  endtask

  // sender drains the unit completely between bursts
  task automatic test_drain_between_bursts();
    repeat (3) begin
      repeat (30) send_seconds(random_seconds());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_dates();
    test_random_dates(600);
    test_beyond_2099(60);
    test_receiver_hold_off();
    test_drain_between_bursts();
    test_random_dates(50);

    wait_for_results();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_dates.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sctd_pkg.sv
hdl/sctd_div.sv
hdl/sctd_cal.sv
hdl/seconds_to_calendar_date_unit.sv
bench/tb_seconds_to_calendar_date_unit.sv
